// ----- design/xrr_pkg.sv -----
// ----------------------------------------------------------------------------
// xrr_pkg
// Widths shared by the ranged xorshift128 generator and its remainder unit.
// ----------------------------------------------------------------------------
package xrr_pkg;

    localparam int WORD_W = 32;              // state word / signed field width
    localparam int LOW_W  = WORD_W - 1;      // nonnegative result width
    localparam int SPAN_W = WORD_W + 1;      // span of a range, up to 2^32
    localparam int CNT_W  = $clog2(LOW_W);   // remainder step counter

endpackage

// ----- design/xrr_mod_divider.sv -----
// ----------------------------------------------------------------------------
// xrr_mod_divider
// Radix-2 restoring remainder unit: 31-bit dividend mod 33-bit divisor,
// one dividend bit per cycle.
// ----------------------------------------------------------------------------
module xrr_mod_divider (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [xrr_pkg::LOW_W-1:0]   i_dividend,
    input  logic [xrr_pkg::SPAN_W-1:0]  i_divisor,
    output logic                        o_done,
    output logic [xrr_pkg::LOW_W-1:0]   o_remainder
);
    import xrr_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(LOW_W - 1);

    t_state              r_state;
    logic [LOW_W-1:0]    r_dvd;
    logic [SPAN_W-1:0]   r_dvs;
    logic [LOW_W-1:0]    r_rem;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_done;

    logic [LOW_W:0]      trial;
    logic                fits;
    logic [LOW_W:0]      diff;
    logic [LOW_W-1:0]    n_rem;

    assign trial = {r_rem, r_dvd[LOW_W-1]};
    assign fits  = {{(SPAN_W-LOW_W-1){1'b0}}, trial} >= r_dvs;
    assign diff  = trial - r_dvs[LOW_W:0];
    assign n_rem = fits ? diff[LOW_W-1:0] : trial[LOW_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_state <= ST_RUN;
                        r_cnt   <= '0;
                    end
                end
                ST_RUN: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == LAST_STEP) begin
                        r_state <= ST_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (r_state == ST_RUN) begin
            r_dvd <= {r_dvd[LOW_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done      = r_done;
    assign o_remainder = r_rem;

    a_start_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_start) |=> (r_state == ST_RUN))
        else $error("remainder unit did not start");

    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_dvs != '0) |-> ({{(SPAN_W-LOW_W){1'b0}}, r_rem} < r_dvs))
        else $error("remainder not below divisor");

    a_done_after_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_state == ST_RUN))
        else $error("done without a run");
endmodule

// ----- design/xorshift128_ranged_random_top.sv -----
// ----------------------------------------------------------------------------
// xorshift128_ranged_random_top
// xorshift128 generator returning the raw word, its low 31 bits, a coin bit
// and a value drawn from an inclusive signed range.
// ----------------------------------------------------------------------------
// channel   dir  fields (low bit up)
// s_axis    in   tdata: range_low[31:0], range_high[63:32]
// m_axis    out  tdata: raw_signed, nonnegative, coin_flip, ranged_value
//                tuser: range_error
// cfg       in   wr_data: seed_value (write reloads state)
//
// One transaction runs in order from accept to result: the state advances
// in the accept cycle, the radix-2 remainder unit runs 31 steps, then
// the output register loads. tready is high only while no transaction is in
// work; the last result may wait in the output register meanwhile. If the
// output is stalled, the finished transaction waits before the output stage.
// Reset (synchronous, active low) loads the state as for a seed of zero.
// ----------------------------------------------------------------------------
module xorshift128_ranged_random_top #(
    parameter logic [31:0] INIT_X = 32'd123456789,
    parameter logic [31:0] INIT_Y = 32'd362436069,
    parameter logic [31:0] INIT_Z = 32'd521288629,
    parameter logic [31:0] INIT_W = 32'd88675123
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic [31:0]  i_cfg_wr_data,   // seed_value
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [63:0]  i_s_axis_tdata,  // range_low[31:0], range_high[63:32]
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [95:0]  o_m_axis_tdata,  // raw_signed[31:0], nonnegative[62:32],
                                          // coin_flip[63], ranged_value[95:64]
    output logic         o_m_axis_tuser   // range_error
);
    import xrr_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_OUT
    } t_state;

    localparam logic [WORD_W-1:0] MASK31 = {1'b0, {(WORD_W-1){1'b1}}};

    t_state              r_state;
    logic [WORD_W-1:0]   r_x, r_y, r_z, r_w;
    logic [WORD_W-1:0]   r_low;
    logic                r_err;
    logic                r_out_valid;
    logic [95:0]         r_out_data;
    logic                r_out_err;

    logic                in_accept;
    logic                out_free;
    logic [WORD_W-1:0]   t_mix;
    logic [WORD_W-1:0]   n_w;
    logic signed [WORD_W+1:0] span;
    logic                span_bad;
    logic [WORD_W-1:0]   seed;
    logic [WORD_W-1:0]   seed_a15;
    logic [WORD_W-1:0]   seed_a1;
    logic [WORD_W-1:0]   seed_a14;
    logic                div_done;
    logic [LOW_W-1:0]    div_rem;
    logic [WORD_W-1:0]   ranged;

    assign in_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free  = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE);

    assign t_mix = r_x ^ (r_x << 11);
    assign n_w   = r_w ^ (r_w >> 19) ^ t_mix ^ (t_mix >> 8);

    assign span = $signed({{2{i_s_axis_tdata[63]}}, i_s_axis_tdata[63:32]}) + 34'sd1
                - $signed({{2{i_s_axis_tdata[31]}}, i_s_axis_tdata[31:0]});
    assign span_bad = span[WORD_W+1] || (span == '0);

    assign seed     = i_cfg_wr_data;
    // arithmetic shifts kept apart so the sign fill survives the masking
    assign seed_a15 = $signed(seed) >>> 15;
    assign seed_a1  = $signed(seed) >>> 1;
    assign seed_a14 = $signed(seed) >>> 14;
    assign ranged   = r_err ? '0 : r_low + {1'b0, div_rem};

    xrr_mod_divider u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (in_accept),
        .i_dividend  (n_w[LOW_W-1:0]),
        .i_divisor   (span[SPAN_W-1:0]),
        .o_done      (div_done),
        .o_remainder (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_x <= INIT_X;
            r_y <= INIT_Y;
            r_z <= INIT_Z;
            r_w <= INIT_W;
        end else begin
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_wr_en) begin
                r_x <= INIT_X ^ seed;
                r_y <= (INIT_Y ^ (seed << 17)) | (seed_a15 & MASK31);
                r_z <= (INIT_Z ^ (seed << 31)) | (seed_a1 & MASK31);
                r_w <= (INIT_W ^ (seed << 18)) | (seed_a14 & MASK31);
            end else if (in_accept) begin
                r_x <= r_y;
                r_y <= r_z;
                r_z <= r_w;
                r_w <= n_w;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_low <= i_s_axis_tdata[31:0];
            r_err <= span_bad;
        end
        if (r_state == S_OUT && out_free) begin
            r_out_data <= {ranged, ~r_w[0], r_w[LOW_W-1:0], r_w};
            r_out_err  <= r_err;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_err;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> !o_s_axis_tready)
        else $error("input ready right after a transaction");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> (o_m_axis_tdata[95:64] == '0))
        else $error("ranged value not zero on range error");

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("remainder done outside divide phase");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_out_valid && !i_m_axis_tready) |=> (r_state == S_OUT))
        else $error("pending result overwritten");
endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the ranged xorshift128 generator against a cycle-free predictor of
// its state words. Range requests stream in through s_axis at random gaps, none in one phase;
// every result on m_axis is compared field by field with the oldest draw.
// The seed is rewritten between phases while the block is drained.
// ----------------------------------------------------------------------------
module tb_top;
    import xrr_pkg::*;

    typedef logic [WORD_W-1:0] word_t;

    typedef struct {
        word_t            lo;
        word_t            hi;
    } range_t;

    typedef struct {
        word_t            raw;
        logic [LOW_W-1:0] low31;
        logic             coin;
        word_t            ranged;
        logic             err;
    } draw_t;

    localparam word_t BASE_X       = 32'd123456789;
    localparam word_t BASE_Y       = 32'd362436069;
    localparam word_t BASE_Z       = 32'd521288629;
    localparam word_t BASE_W       = 32'd88675123;
    localparam word_t LOW_MASK     = 32'h7FFF_FFFF;
    localparam word_t MIN_S        = 32'h8000_0000;
    localparam word_t MAX_S        = 32'h7FFF_FFFF;
    localparam int    LIMIT_CYCLES = 1_000_000;
    localparam int    PHASES       = 8;
    localparam int    PHASE_ITEMS  = 210;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_cfg_wr_en     = 1'b0;
    logic [31:0] i_cfg_wr_data   = '0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [63:0] i_s_axis_tdata  = '0;  // range_low[31:0], range_high[63:32]
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [95:0] o_m_axis_tdata;        // raw_signed, nonnegative, coin_flip, ranged_value
    logic        o_m_axis_tuser;        // range_error

    xorshift128_ranged_random_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    word_t  st_x, st_y, st_z, st_w;
    range_t range_q[$];
    draw_t  draws_q[$];
    int     mismatches = 0;
    int     cycle_cnt  = 0;
    bit     no_idle    = 1'b0;
    logic   range_taken = 1'b0;

    function automatic word_t asr(input word_t v, input int k);
        logic signed [WORD_W-1:0] sv;
        sv = v;
        return sv >>> k;
    endfunction

    task automatic reseed_words(input word_t s);
        st_x = BASE_X ^ s;
        st_y = (BASE_Y ^ (s << 17)) | (asr(s, 15) & LOW_MASK);
        st_z = (BASE_Z ^ (s << 31)) | (asr(s, 1) & LOW_MASK);
        st_w = (BASE_W ^ (s << 18)) | (asr(s, 14) & LOW_MASK);
    endtask

    task automatic push_range(input word_t lo, input word_t hi);
        range_t r;
        r.lo = lo;
        r.hi = hi;
        range_q.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input word_t got, input word_t want);
        mismatches++;
        if (mismatches <= 40) begin
            $display("mismatch %s: got %h expected %h (cycle %0d)", what, got, want, cycle_cnt);
        end
    endtask

    task automatic wait_drained();
        while (range_q.size() != 0 || i_s_axis_tvalid || draws_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    // driver
    range_t nxt;
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_s_axis_tvalid || range_taken)) begin
            if (range_q.size() != 0 && (no_idle || $urandom_range(0, 99) >= 26)) begin
                nxt = range_q.pop_front();
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata  <= {nxt.hi, nxt.lo};
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        i_m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 26);
    end

    // monitor and predictor
    draw_t               want;
    word_t               mix;
    logic signed [63:0]  lo_l, hi_l, span_l, rem_l, pick_l;

    always @(posedge i_clk) begin
        range_taken <= i_rst_n && i_s_axis_tvalid && o_s_axis_tready;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (draws_q.size() == 0) begin
                report_mismatch("unexpected transaction", o_m_axis_tdata[31:0], '0);
            end else begin
                want = draws_q.pop_front();
                if (o_m_axis_tdata[31:0] !== want.raw)
                    report_mismatch("raw_signed", o_m_axis_tdata[31:0], want.raw);
                if (o_m_axis_tdata[62:32] !== want.low31)
                    report_mismatch("nonnegative", word_t'(o_m_axis_tdata[62:32]),
                                    word_t'(want.low31));
                if (o_m_axis_tdata[63] !== want.coin)
                    report_mismatch("coin_flip", word_t'(o_m_axis_tdata[63]), word_t'(want.coin));
                if (o_m_axis_tdata[95:64] !== want.ranged)
                    report_mismatch("ranged_value", o_m_axis_tdata[95:64], want.ranged);
                if (o_m_axis_tuser !== want.err)
                    report_mismatch("range_error", word_t'(o_m_axis_tuser), word_t'(want.err));
            end
        end
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready) begin
            mix  = st_x ^ (st_x << 11);
            st_x = st_y;
            st_y = st_z;
            st_z = st_w;
            st_w = st_w ^ (st_w >> 19) ^ mix ^ (mix >> 8);
            want.raw   = st_w;
            want.low31 = st_w[LOW_W-1:0];
            want.coin  = ~st_w[0];
            lo_l   = $signed(i_s_axis_tdata[31:0]);
            hi_l   = $signed(i_s_axis_tdata[63:32]);
            span_l = hi_l + 1 - lo_l;
            if (span_l <= 0) begin
                want.err    = 1'b1;
                want.ranged = '0;
            end else begin
                rem_l       = st_w[LOW_W-1:0];
                pick_l      = lo_l + rem_l % span_l;
                want.err    = 1'b0;
                want.ranged = pick_l[WORD_W-1:0];
            end
            draws_q.push_back(want);
        end
    end

    initial begin
        wait (cycle_cnt == LIMIT_CYCLES);
        $display("timeout after %0d cycles", LIMIT_CYCLES);
        $display("** xorshift128_ranged_random_top: FAILED **");
        $finish;
    end

    // stimulus
    word_t a, b, seed, span_m1;
    word_t edge_vals[6];

    initial begin
        edge_vals = '{MIN_S, MIN_S + 1, 32'hFFFF_FFFF, 32'h0, 32'h1, MAX_S};
        reseed_words('0);
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: unit spans, full span, empty and inverted ranges, edges
        push_range(32'd0, 32'd0);
        push_range(32'd0, 32'hFFFF_FFFF);
        push_range(32'd5, 32'd4);
        push_range(MIN_S, MAX_S);
        push_range(MAX_S, MIN_S);
        push_range(MAX_S, MAX_S);
        push_range(MIN_S, MIN_S);
        push_range(-32'sd10, 32'sd10);
        push_range(32'd0, 32'd1);
        push_range(MIN_S, MIN_S + 1);
        push_range(MAX_S - 1, MAX_S);
        push_range(32'd0, MAX_S);
        push_range(32'd0, MAX_S - 1);
        push_range(MIN_S, 32'hFFFF_FFFF);
        push_range(32'hFFFF_FFFF, 32'd0);
        push_range(32'd1, 32'd0);
        push_range(-32'sd5, -32'sd5);
        push_range(32'hFFFF_FFFF, MAX_S);
        push_range(MIN_S, 32'd0);
        push_range(32'd1, MAX_S);
        push_range(MIN_S + 1, MIN_S);
        push_range(32'hFFFF_0000, 32'h0000_FFFF);
        wait_drained();

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       seed = MAX_S;
                1:       seed = MIN_S;
                2:       seed = 32'hFFFF_FFFF;
                4:       seed = 32'h0000_0001;
                6:       seed = 32'h0000_0000;
                default: seed = $urandom;
            endcase
            @(negedge i_clk);
            i_cfg_wr_en   <= 1'b1;
            i_cfg_wr_data <= seed;
            reseed_words(seed);
            @(negedge i_clk);
            i_cfg_wr_en <= 1'b0;
            no_idle = (ph == 2);

            repeat (PHASE_ITEMS) begin
                a = $urandom;
                b = $urandom;
                case ($urandom_range(0, 5))
                    0: push_range(a, b);
                    1: push_range(a, a + $urandom_range(0, 255));
                    2: begin
                        if ($signed(a) <= $signed(b)) push_range(a, b);
                        else push_range(b, a);
                    end
                    3: begin
                        span_m1 = (word_t'(1) << $urandom_range(0, 31)) - 1;
                        push_range(asr(a, $urandom_range(0, 31)), asr(a, 0) + span_m1);
                    end
                    4: push_range(a, a - $urandom_range(1, 8));
                    default: push_range(edge_vals[$urandom_range(0, 5)],
                                        edge_vals[$urandom_range(0, 5)]);
                endcase
            end
            wait_drained();
            no_idle = 1'b0;
        end

        repeat (60) @(posedge i_clk);
        if (draws_q.size() != 0) begin
            report_mismatch("missing transactions", word_t'(draws_q.size()), '0);
        end
        if (mismatches == 0) begin
            $display("** xorshift128_ranged_random_top: PASSED **");
        end else begin
            $display("** xorshift128_ranged_random_top: FAILED **");
        end
        $finish;
    end

endmodule
